FILE: sv/mstbl_pkg.sv
// Shared types and codes of the multi-scope token bucket limiter.
package mstbl_pkg;

	// function codes of an input beat
	localparam logic [1:0] FUNC_ACQUIRE = 2'd0;
	localparam logic [1:0] FUNC_BACKOFF = 2'd1;
	localparam logic [1:0] FUNC_CLEAR   = 2'd2;

	// target scope codes
	localparam logic [1:0] TGT_USER   = 2'd0;
	localparam logic [1:0] TGT_CHAT   = 2'd1;
	localparam logic [1:0] TGT_GLOBAL = 2'd2;
	localparam logic [1:0] TGT_ALL    = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_USER_CAP   = 3'd0;
	localparam logic [2:0] REG_USER_RATE  = 3'd1;
	localparam logic [2:0] REG_CHAT_CAP   = 3'd2;
	localparam logic [2:0] REG_CHAT_RATE  = 3'd3;
	localparam logic [2:0] REG_GLOBAL_CAP = 3'd4;
	localparam logic [2:0] REG_GLOBAL_RATE = 3'd5;
	localparam logic [2:0] REG_SCOPE_EN   = 3'd6;

	// bucket scan positions
	localparam logic [1:0] SEL_USER   = 2'd0;
	localparam logic [1:0] SEL_CHAT   = 2'd1;
	localparam logic [1:0] SEL_GLOBAL = 2'd2;
	localparam logic [1:0] SEL_END    = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SEL, ST_RD, ST_EV, ST_ADD, ST_CHK, ST_DIV, ST_CMT,
		ST_BO, ST_CLR, ST_DONE
	} state_t;

endpackage

FILE: sv/multi_scope_token_bucket_limiter.sv
// Top level of the multi-scope token bucket limiter.
// One item is handled at a time. An acquire reads, refills and checks each
// involved bucket in turn from a table memory with a registered read, running
// the iterative divider for each bucket that denies on tokens, then walks the
// three bucket positions for write-back, one per cycle. The entry-valid bits
// live in flip-flops, so reset and clear-all take effect at once with no sweep.
module multi_scope_token_bucket_limiter #(
	parameter int USER_SLOTS        = 32,
	parameter int CHAT_SLOTS        = 32,
	parameter int MIN_BACKOFF_TICKS = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [47:0] now_ticks,
	input  logic        user_present,
	input  logic [4:0]  user_slot,
	input  logic        chat_present,
	input  logic [4:0]  chat_slot,
	input  logic [31:0] tokens_requested,
	input  logic [1:0]  target_scope,
	input  logic [31:0] backoff_ticks,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        allowed,
	output logic [31:0] retry_after_ticks
);
	import mstbl_pkg::*;

	localparam int NB = USER_SLOTS + CHAT_SLOTS + 1;
	localparam int AW = $clog2(NB);
	localparam logic [AW-1:0] GIDX = AW'(USER_SLOTS + CHAT_SLOTS);
	localparam logic [AW-1:0] CBASE = AW'(USER_SLOTS);
	localparam logic [48:0] MINB = 49'(MIN_BACKOFF_TICKS);

	// configuration registers
	logic [31:0] ucap_q, urate_q, ccap_q, crate_q, gcap_q, grate_q;
	logic [2:0]  scope_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ucap_q <= 32'd655360; urate_q <= 32'd655;
			ccap_q <= 32'd655360; crate_q <= 32'd655;
			gcap_q <= 32'd655360; grate_q <= 32'd655;
			scope_en_q <= 3'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_USER_CAP:    ucap_q <= cfg_data;
				REG_USER_RATE:   urate_q <= cfg_data;
				REG_CHAT_CAP:    ccap_q <= cfg_data;
				REG_CHAT_RATE:   crate_q <= cfg_data;
				REG_GLOBAL_CAP:  gcap_q <= cfg_data;
				REG_GLOBAL_RATE: grate_q <= cfg_data;
				REG_SCOPE_EN:    scope_en_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// slot wrap as constant lookup
	logic [AW-1:0] uidx_in, cidx_in;
	always_comb begin
		uidx_in = '0;
		cidx_in = '0;
		for (int k = 0; k < 32; k++) begin
			if (user_slot == 5'(k)) uidx_in = AW'(k % USER_SLOTS);
			if (chat_slot == 5'(k)) cidx_in = CBASE + AW'(k % CHAT_SLOTS);
		end
	end

	state_t state_q, state_d;

	// item registers
	logic [1:0]    tgt_q;
	logic [47:0]   now_q;
	logic [31:0]   req_q, bo_q;
	logic [AW-1:0] uidx_q, cidx_q;
	logic [3:0]    use_q;
	logic [1:0]    bsel_q;

	// per-bucket results
	logic [3:0]  wr_q;
	logic [31:0] tok_q  [4];
	logic [47:0] last_q [4];
	logic        ok_q;
	logic [31:0] worst_q;

	// working registers
	logic [31:0] cur_tok_q;
	logic [47:0] cur_last_q;
	logic [63:0] prod_q;

	// valid bits
	logic [NB-1:0] bkt_valid_q, bo_valid_q;

	// table memories: tokens/last refill and backoff deadline
	logic [79:0] mem_tl [NB];
	logic [47:0] mem_bo [NB];
	logic [79:0] tl_rd_q;
	logic [47:0] bo_rd_q;

	// control from FSM
	logic in_acc, rd_en, tl_we, bo_we, div_start;

	// divider
	logic        div_busy, div_done, div_rnz;
	logic [31:0] div_quo;
	logic [31:0] need;

	// bucket selection
	logic [AW-1:0] cur_idx;
	logic [31:0]   cur_cap, cur_rate;
	always_comb begin
		case (bsel_q)
			SEL_USER:   begin cur_idx = uidx_q; cur_cap = ucap_q; cur_rate = urate_q; end
			SEL_CHAT:   begin cur_idx = cidx_q; cur_cap = ccap_q; cur_rate = crate_q; end
			default:    begin cur_idx = GIDX;   cur_cap = gcap_q; cur_rate = grate_q; end
		endcase
	end

	// EV stage decode
	logic [47:0] bo_eff, el, bo_wait;
	logic        bo_hit, cur_valid;
	assign cur_valid = bkt_valid_q[cur_idx];
	assign bo_eff    = bo_valid_q[cur_idx] ? bo_rd_q : 48'd0;
	assign bo_hit    = (now_q < bo_eff);
	assign bo_wait   = bo_eff - now_q;
	assign el        = now_q - tl_rd_q[47:0];

	// refill add
	logic [64:0] sum;
	assign sum  = {33'd0, cur_tok_q} + {1'b0, prod_q};
	assign need = req_q - cur_tok_q;

	// wait from divider, rounded up and saturated
	logic [32:0] div_wait;
	assign div_wait = {1'b0, div_quo} + {32'd0, div_rnz};

	// backoff deadline
	logic [48:0] bo_len, bo_until;
	assign bo_len   = ({17'd0, bo_q} < MINB) ? MINB : {17'd0, bo_q};
	assign bo_until = {1'b0, now_q} + bo_len;

	// commit data
	logic [31:0] cmt_tok;
	assign cmt_tok = ok_q ? (tok_q[bsel_q] - req_q) : tok_q[bsel_q];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) begin
				case (func)
					FUNC_ACQUIRE: state_d = ST_SEL;
					FUNC_BACKOFF: state_d = ST_BO;
					FUNC_CLEAR:   state_d = ST_CLR;
					default:      state_d = ST_DONE;
				endcase
			end
			ST_SEL: begin
				if (bsel_q == SEL_END) state_d = ST_CMT;
				else if (use_q[bsel_q]) state_d = ST_RD;
			end
			ST_RD: state_d = ST_EV;
			ST_EV: begin
				if (bo_hit) state_d = ST_SEL;
				else if (cur_valid && now_q > tl_rd_q[47:0] && el[47:32] == 16'd0)
					state_d = ST_ADD;
				else state_d = ST_CHK;
			end
			ST_ADD: state_d = ST_CHK;
			ST_CHK: begin
				if (cur_tok_q < req_q && cur_rate != 32'd0) state_d = ST_DIV;
				else state_d = ST_SEL;
			end
			ST_DIV: if (div_done) state_d = ST_SEL;
			ST_CMT: if (bsel_q == SEL_GLOBAL) state_d = ST_DONE;
			ST_BO:  state_d = ST_DONE;
			ST_CLR: state_d = ST_DONE;
			ST_DONE: if (!out_valid || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		rd_en     = (state_q == ST_RD);
		tl_we     = (state_q == ST_CMT) && wr_q[bsel_q];
		bo_we     = (state_q == ST_BO);
		div_start = (state_q == ST_CHK) && (cur_tok_q < req_q) && (cur_rate != 32'd0);
	end
	assign in_acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// memories
	logic [AW-1:0] bo_addr;
	always_comb begin
		case (tgt_q)
			TGT_USER: bo_addr = uidx_q;
			TGT_CHAT: bo_addr = cidx_q;
			default:  bo_addr = GIDX;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tl_we) mem_tl[cur_idx] <= {cmt_tok, last_q[bsel_q]};
		if (bo_we) mem_bo[bo_addr] <= bo_until[48] ? 48'hFFFF_FFFF_FFFF : bo_until[47:0];
		if (rd_en) begin
			tl_rd_q <= mem_tl[cur_idx];
			bo_rd_q <= mem_bo[cur_idx];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bkt_valid_q <= '0;
			bo_valid_q  <= '0;
		end else begin
			if (tl_we) bkt_valid_q[cur_idx] <= 1'b1;
			if (bo_we) bo_valid_q[bo_addr] <= 1'b1;
			if (state_q == ST_CLR) begin
				if (tgt_q == TGT_ALL) begin
					bkt_valid_q <= '0;
					bo_valid_q  <= '0;
				end else begin
					bkt_valid_q[bo_addr] <= 1'b0;
					bo_valid_q[bo_addr]  <= 1'b0;
				end
			end
		end
	end

	// control counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsel_q <= SEL_USER;
			wr_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_acc) begin
					bsel_q <= SEL_USER;
					wr_q   <= '0;
				end
				ST_SEL: begin
					if (bsel_q == SEL_END) bsel_q <= SEL_USER;
					else if (!use_q[bsel_q]) bsel_q <= bsel_q + 2'd1;
				end
				ST_EV:  if (bo_hit) bsel_q <= bsel_q + 2'd1;
				ST_CHK: begin
					wr_q[bsel_q] <= 1'b1;
					if (!(cur_tok_q < req_q && cur_rate != 32'd0)) bsel_q <= bsel_q + 2'd1;
				end
				ST_DIV: if (div_done) bsel_q <= bsel_q + 2'd1;
				ST_CMT: bsel_q <= bsel_q + 2'd1;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_acc) begin
				tgt_q  <= target_scope;
				now_q  <= now_ticks;
				req_q  <= tokens_requested;
				bo_q   <= backoff_ticks;
				uidx_q <= uidx_in;
				cidx_q <= cidx_in;
				use_q  <= {1'b0, scope_en_q[2], chat_present & scope_en_q[1],
					user_present & scope_en_q[0]};
				ok_q    <= (func != 2'd3);
				worst_q <= '0;
			end
			ST_EV: begin
				prod_q <= 64'(el[31:0]) * 64'(cur_rate);
				if (bo_hit) begin
					ok_q <= 1'b0;
					if (bo_wait[47:32] != 16'd0) worst_q <= 32'hFFFF_FFFF;
					else if (bo_wait[31:0] > worst_q) worst_q <= bo_wait[31:0];
				end
				if (!cur_valid) begin
					cur_tok_q  <= cur_cap;
					cur_last_q <= now_q;
				end else if (now_q > tl_rd_q[47:0]) begin
					cur_tok_q  <= (el[47:32] != 16'd0) ? cur_cap : tl_rd_q[79:48];
					cur_last_q <= now_q;
				end else begin
					cur_tok_q  <= tl_rd_q[79:48];
					cur_last_q <= tl_rd_q[47:0];
				end
			end
			ST_ADD: cur_tok_q <= (sum > {33'd0, cur_cap}) ? cur_cap : sum[31:0];
			ST_CHK: begin
				tok_q[bsel_q]  <= cur_tok_q;
				last_q[bsel_q] <= cur_last_q;
				if (cur_tok_q < req_q) begin
					ok_q <= 1'b0;
					if (cur_rate == 32'd0 && worst_q == 32'd0) worst_q <= 32'd1;
				end
			end
			ST_DIV: if (div_done) begin
				if (div_wait[32]) worst_q <= 32'hFFFF_FFFF;
				else if (div_wait[31:0] > worst_q) worst_q <= div_wait[31:0];
			end
			default: ;
		endcase
	end

	mstbl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (need),
		.divisor  (cur_rate),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo),
		.rem_nz   (div_rnz)
	);

	// output register
	logic        out_valid_q, allowed_q;
	logic [31:0] retry_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			allowed_q <= ok_q;
			retry_q   <= ok_q ? 32'd0 : worst_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign allowed           = allowed_q;
	assign retry_after_ticks = retry_q;

	// checks
	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == ST_DIV))
		else $error("divider busy outside divide state");
	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		tl_we |=> bkt_valid_q[$past(cur_idx)])
		else $error("written bucket not marked valid");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("second beat taken while busy");
endmodule

FILE: sv/mstbl_div.sv
// Iterative 32-bit restoring divider, one quotient bit per cycle.
module mstbl_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [31:0] quotient,
	output logic        rem_nz
);
	logic [32:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] shl;
	logic [32:0] diff;
	logic        take;

	// one trial subtraction per cycle
	assign shl  = {rem_q[31:0], quo_q[31]};
	assign diff = shl - {1'b0, dvs_q};
	assign take = (shl >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff : shl;
			quo_q <= {quo_q[30:0], take};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;
	assign rem_nz   = (rem_q != '0);
endmodule
